/* hdl/hufdec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hufdec_pkg;

    // Tree size and alphabet size.
    localparam int MAX_SYMBOLS = 256;
    localparam int NODE_COUNT  = 512;

    // Field widths fixed by the item layout.
    localparam int IDX_W     = 9;
    localparam int ENTRY_W   = 2 * IDX_W + 1;
    localparam int NODE_AW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NODE_AW_X = (NODE_AW > IDX_W) ? NODE_AW : IDX_W;

    localparam logic [IDX_W-1:0] END_SYMBOL_RESET = IDX_W'((MAX_SYMBOLS + 1) % 512);

    typedef enum logic [1:0] {
        OP_DECODE  = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SYMBOL = 2'd1,
        ST_END    = 2'd2,
        ST_ERROR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             is_leaf;
        logic [IDX_W-1:0] left_or_symbol;
        logic [IDX_W-1:0] right_index;
    } t_entry;

    typedef struct packed {
        t_opcode          opcode;
        logic             code_bit;
        logic [IDX_W-1:0] node_index;
        logic             node_is_leaf;
        logic [IDX_W-1:0] left_or_symbol;
        logic [IDX_W-1:0] right_index;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] symbol;
    } t_result;

    // True when a node index names an entry of the table.
    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return int'(idx) < NODE_COUNT;
    endfunction

    // Memory address of a node index.
    function automatic logic [NODE_AW-1:0] idx_to_addr(input logic [IDX_W-1:0] idx);
        logic [NODE_AW_X-1:0] wide;
        wide = NODE_AW_X'(idx);
        return wide[NODE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/hufdec_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module hufdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/hufdec_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

// Register file holding the end symbol.
module hufdec_cfg
    import hufdec_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output logic      [IDX_W-1:0] o_end_symbol
);

    logic [IDX_W-1:0] r_end_symbol;
    logic [IDX_W-1:0] n_end_symbol;

    always_comb begin
        n_end_symbol = r_end_symbol;
        if (psel && penable && pwrite && !paddr[2]) begin
            n_end_symbol = pwdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_symbol <= END_SYMBOL_RESET;
        end else begin
            r_end_symbol <= n_end_symbol;
        end
    end

    assign prdata       = paddr[2] ? 32'd0 : 32'(r_end_symbol);
    assign pready       = 1'b1;
    assign o_end_symbol = r_end_symbol;

endmodule

`default_nettype wire

/* hdl/hufdec_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tree walk engine. The entry of the current node and of the root are kept in
// registers, so a decoded bit needs a single node memory read: the child.
module hufdec_walk
    import hufdec_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_item            i_item,
    input  wire logic [IDX_W-1:0] i_end_symbol,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res
);

    t_state           r_state,      n_state;
    logic [IDX_W-1:0] r_cur_node,   n_cur_node;
    logic             r_ended,      n_ended;
    t_entry           r_cur_entry,  n_cur_entry;
    t_entry           r_root_entry, n_root_entry;
    logic [IDX_W-1:0] r_child,      n_child;
    t_result          r_res,        n_res;

    logic             ram_we;
    t_entry           ram_wdata;
    t_entry           ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;
    logic [IDX_W-1:0] child;
    t_result          res_now;
    logic             res_fire;

    assign child     = i_item.code_bit ? r_cur_entry.right_index : r_cur_entry.left_or_symbol;
    assign ram_wdata = '{is_leaf:        i_item.node_is_leaf,
                         left_or_symbol: i_item.left_or_symbol,
                         right_index:    i_item.right_index};
    assign ram_rdata = t_entry'(ram_rbits);

    hufdec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_to_addr(i_item.node_index)),
        .i_wdata (ENTRY_W'(ram_wdata)),
        .i_raddr (idx_to_addr(child)),
        .o_rdata (ram_rbits)
    );

    always_comb begin
        n_state      = r_state;
        n_cur_node   = r_cur_node;
        n_ended      = r_ended;
        n_cur_entry  = r_cur_entry;
        n_root_entry = r_root_entry;
        n_child      = r_child;
        n_res        = r_res;
        ram_we       = 1'b0;
        res_now      = '{status: ST_NONE, symbol: '0};
        res_fire     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    res_fire = 1'b1;
                    unique case (i_item.opcode)
                        OP_DECODE: begin
                            if (r_ended) begin
                                res_now.status = ST_ERROR;
                            end else if (r_cur_entry.is_leaf || !idx_in_range(child)) begin
                                res_now.status = ST_ERROR;
                                n_cur_node     = '0;
                                n_cur_entry    = r_root_entry;
                            end else begin
                                // Child entry arrives from the memory next cycle.
                                res_fire = 1'b0;
                                n_child  = child;
                                n_state  = S_READ;
                            end
                        end
                        OP_WRITE: begin
                            if (idx_in_range(i_item.node_index)) begin
                                ram_we = 1'b1;
                                if (i_item.node_index == '0) begin
                                    n_root_entry = ram_wdata;
                                end
                                if (i_item.node_index == r_cur_node) begin
                                    n_cur_entry = ram_wdata;
                                end
                            end
                        end
                        OP_RESTART: begin
                            n_cur_node  = '0;
                            n_cur_entry = r_root_entry;
                            n_ended     = 1'b0;
                        end
                        OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                res_fire = 1'b1;
                if (!ram_rdata.is_leaf) begin
                    n_cur_node  = r_child;
                    n_cur_entry = ram_rdata;
                end else begin
                    n_cur_node  = '0;
                    n_cur_entry = r_root_entry;
                    if (ram_rdata.left_or_symbol == i_end_symbol) begin
                        n_ended        = 1'b1;
                        res_now.status = ST_END;
                    end else begin
                        res_now.status = ST_SYMBOL;
                        res_now.symbol = ram_rdata.left_or_symbol;
                    end
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_fire) begin
            if (i_res_ready) begin
                n_state = S_IDLE;
            end else begin
                n_res   = res_now;
                n_state = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_node <= '0;
            r_ended    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_node <= n_cur_node;
            r_ended    <= n_ended;
        end
        r_cur_entry  <= n_cur_entry;
        r_root_entry <= n_root_entry;
        r_child      <= n_child;
        r_res        <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = res_fire || (r_state == S_EMIT);
    assign o_res       = (r_state == S_EMIT) ? r_res : res_now;

endmodule

`default_nettype wire

/* hdl/huffman_tree_bit_decoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial Huffman tree-walk decoder.
// Input items arrive on the s_axis channel: tuser carries the opcode (decode a
// bit, write a node table entry, restart at the root, no-op) and tdata the code bit
// and the node entry fields. Every input item yields exactly one result item
// on the m_axis channel: tuser carries the status and tdata the symbol.
// The node table must be loaded with write items before bits are decoded;
// entry 0 is the root. The end symbol is set through the APB port, which must
// only be written while no item is in flight; the block does not enforce this.
// A write, restart or no-op item, and a decoded bit that fails at once, finish
// in the cycle they are accepted. A decoded bit that steps to a child waits for
// the registered read of the node memory; the current and root entries are held
// in registers so one read per bit is enough. A result reaches the output
// register at the end of the item's last cycle. No further item is taken while
// one is being worked on. Reset sets the node index to the root, clears the
// end-of-stream flag and restores the end symbol; held current and root entries
// are not cleared, and the node table is not cleared and needs no clearing pass.
// When the receiver stalls, a finished result waits in the output register
// while the next item is accepted; that item's result then holds inside the
// engine until the output register is free.
module huffman_tree_bit_decoder_top
    import hufdec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: code_bit[0], node_index[9:1], node_is_leaf[10],
    //        left_or_symbol[19:11], right_index[28:20], zero fill [31:29]
    input  wire logic [31:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // Result channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: symbol[8:0], zero fill [15:9]
    output logic      [15:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic      [1:0]  m_axis_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_item            item;
    logic [IDX_W-1:0] end_symbol;
    logic             res_valid;
    logic             res_ready;
    t_result          res;

    logic             r_out_valid, n_out_valid;
    t_result          r_out,       n_out;

    // Unpack the input item.
    assign item.opcode         = t_opcode'(s_axis_tuser);
    assign item.code_bit       = s_axis_tdata[0];
    assign item.node_index     = s_axis_tdata[9:1];
    assign item.node_is_leaf   = s_axis_tdata[10];
    assign item.left_or_symbol = s_axis_tdata[19:11];
    assign item.right_index    = s_axis_tdata[28:20];

    hufdec_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_end_symbol (end_symbol)
    );

    hufdec_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (item),
        .i_end_symbol (end_symbol),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // Output register: it can take a new result whenever it is empty or its
    // current result is being taken in this cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out.symbol);
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire
